>>> design/periodic_tick_event_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the periodic tick event table
// Clocked on clk_i; the first form is disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TICK_EVENT_TABLE_ASSERT_SVH
`define PERIODIC_TICK_EVENT_TABLE_ASSERT_SVH

`define PTET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PTET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/ptet_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptet_pkg
// Shared types and constants of the periodic tick event table.
// ---------------------------------------------------------------------------
package ptet_pkg;

  localparam int unsigned CHANNEL_COUNT_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF    = 32;
  localparam int unsigned CHAN_ID_BITS      = 3;
  localparam int unsigned PERIOD_BITS       = 32;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  localparam logic KIND_SET_REPLY = 1'b0;
  localparam logic KIND_FIRE      = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [CHAN_ID_BITS-1:0] chan;
    logic                    failed;
    logic                    last;
  } res_t;

endpackage

>>> design/ptet_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptet_cell
// One slot of the channel ring: active flag, channel tag, reload and count.
// On every shift takes its neighbor's contents, or at the tail the new entry.
// ---------------------------------------------------------------------------
module ptet_cell #(
  parameter int unsigned TAG_BITS   = 3,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  shift_i,
  input  logic                  active_i,
  input  logic [TAG_BITS-1:0]   tag_i,
  input  logic [COUNT_BITS-1:0] reload_i,
  input  logic [COUNT_BITS-1:0] count_i,
  output logic                  active_o,
  output logic [TAG_BITS-1:0]   tag_o,
  output logic [COUNT_BITS-1:0] reload_o,
  output logic [COUNT_BITS-1:0] count_o
);

  logic                  active_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [COUNT_BITS-1:0] reload_q;
  logic [COUNT_BITS-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tag_q    <= TAG_BITS'(INDEX);
    end else if (shift_i) begin
      active_q <= active_i;
      tag_q    <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      reload_q <= reload_i;
      count_q  <= count_i;
    end
  end

  assign active_o = active_q;
  assign tag_o    = tag_q;
  assign reload_o = reload_q;
  assign count_o  = count_q;

endmodule

>>> design/ptet_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptet_ctrl
// Request sequencer: works on the ring head one step per cycle unless held
// by a stalled fire, writes back at the tail and drives the result register.
// ---------------------------------------------------------------------------
module ptet_ctrl #(
  parameter int unsigned CHANNEL_COUNT = 8,
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned TAG_BITS      = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     req_type_i,
  input  logic [ptet_pkg::PERIOD_BITS-1:0] period_ticks_i,
  input  logic [ptet_pkg::CHAN_ID_BITS-1:0] target_channel_i,
  input  logic                           head_active_i,
  input  logic [TAG_BITS-1:0]            head_tag_i,
  input  logic [COUNT_BITS-1:0]          head_reload_i,
  input  logic [COUNT_BITS-1:0]          head_count_i,
  output logic                           shift_o,
  output logic                           new_active_o,
  output logic [TAG_BITS-1:0]            new_tag_o,
  output logic [COUNT_BITS-1:0]          new_reload_o,
  output logic [COUNT_BITS-1:0]          new_count_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ptet_pkg::res_t                 res_o
);
  import ptet_pkg::*;

  `include "periodic_tick_event_table_assert.svh"

  localparam int unsigned CMP_BITS = (TAG_BITS > CHAN_ID_BITS) ? TAG_BITS : CHAN_ID_BITS;
  localparam logic [TAG_BITS-1:0] LAST_STEP = TAG_BITS'(CHANNEL_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e                  state_q;
  logic [TAG_BITS-1:0]     step_q;
  logic                    pend_v_q;
  logic [TAG_BITS-1:0]     pend_ch_q;
  logic                    out_v_q;
  res_t                    res_q;
  req_e                    req_q;
  logic [COUNT_BITS-1:0]   period_q;
  logic [CHAN_ID_BITS-1:0] target_q;

  logic                  in_acc;
  logic                  out_free;
  logic [COUNT_BITS-1:0] dec;
  logic                  hit;
  logic                  tag_match;
  logic                  adv;
  logic                  claim;
  logic                  load_out;
  logic                  fin_done;
  res_t                  res_d;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_v_q || !out_stall_i;
  assign dec        = head_count_i - COUNT_BITS'(1);
  assign hit        = head_active_i && (dec == '0);
  assign tag_match  = (CMP_BITS'(head_tag_i) == CMP_BITS'(target_q));
  assign new_tag_o  = head_tag_i;

  always_comb begin
    new_active_o = head_active_i;
    new_reload_o = head_reload_i;
    new_count_o  = head_count_i;
    adv          = 1'b0;
    claim        = 1'b0;
    load_out     = 1'b0;
    fin_done     = 1'b0;
    res_d        = res_q;
    case (state_q)
      ST_SCAN: begin
        case (req_q)
          REQ_TICK: begin
            if (head_active_i) begin
              new_count_o = hit ? head_reload_i : dec;
            end
            adv = !(hit && pend_v_q && !out_free);
            if (hit && pend_v_q && out_free) begin
              load_out = 1'b1;
              res_d    = '{kind: KIND_FIRE, chan: CHAN_ID_BITS'(pend_ch_q),
                           failed: 1'b0, last: 1'b0};
            end
          end
          REQ_SET: begin
            adv = 1'b1;
            if (!head_active_i && !pend_v_q) begin
              claim        = 1'b1;
              new_active_o = 1'b1;
              new_reload_o = period_q;
              new_count_o  = period_q;
            end
          end
          REQ_CLEAR: begin
            adv = 1'b1;
            if (tag_match) begin
              new_active_o = 1'b0;
            end
          end
          default: begin
            adv = 1'b1;
          end
        endcase
      end
      ST_FINISH: begin
        case (req_q)
          REQ_TICK: begin
            fin_done = !pend_v_q || out_free;
            if (pend_v_q && out_free) begin
              load_out = 1'b1;
              res_d    = '{kind: KIND_FIRE, chan: CHAN_ID_BITS'(pend_ch_q),
                           failed: 1'b0, last: 1'b1};
            end
          end
          REQ_SET: begin
            fin_done = out_free;
            if (out_free) begin
              load_out = 1'b1;
              res_d    = '{kind: KIND_SET_REPLY,
                           chan: pend_v_q ? CHAN_ID_BITS'(pend_ch_q) : '0,
                           failed: !pend_v_q, last: 1'b1};
            end
          end
          default: begin
            fin_done = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign shift_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      res_q    <= '0;
    end else begin
      if (load_out) begin
        out_v_q <= 1'b1;
        res_q   <= res_d;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q  <= ST_SCAN;
            step_q   <= '0;
            pend_v_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (adv) begin
            if ((req_q == REQ_TICK && hit) || claim) begin
              pend_v_q <= 1'b1;
            end
            if (step_q == LAST_STEP) begin
              step_q  <= '0;
              state_q <= ST_FINISH;
            end else begin
              step_q <= step_q + TAG_BITS'(1);
            end
          end
        end
        ST_FINISH: begin
          if (fin_done) begin
            state_q  <= ST_IDLE;
            pend_v_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= req_e'(req_type_i);
      period_q <= COUNT_BITS'(period_ticks_i);
      target_q <= target_channel_i;
    end
    if (state_q == ST_SCAN && adv && ((req_q == REQ_TICK && hit) || claim)) begin
      pend_ch_q <= head_tag_i;
    end
  end

  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

  `PTET_ASSERT(a_hold_ring, (state_q == ST_SCAN && !adv) |=> $stable(step_q),
               "ring moved while held")
  `PTET_ASSERT(a_scan_end,
               (state_q == ST_SCAN && adv && step_q == LAST_STEP) |=> (state_q == ST_FINISH),
               "scan did not end")
  `PTET_ASSERT(a_step_range, step_q <= LAST_STEP, "step counter out of range")
  `PTET_ASSERT(a_fail_chan,
               (out_v_q && res_q.failed) |->
                 (res_q.chan == '0 && res_q.kind == KIND_SET_REPLY && res_q.last),
               "bad failure reply")
  `PTET_ASSERT_ALWAYS(a_no_load_full, load_out |-> out_free, "result overwritten")

endmodule

>>> design/periodic_tick_event_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_tick_event_table
// Table of periodic timer channels kept in a ring of cells. Set claims the
// lowest free channel, clear frees one, tick counts all active channels down
// and reports each one that fires, in channel order.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o  | req_type, period_ticks, target_channel
//  out     | output    | out_valid_o / out_stall_i| result_kind, channel_id, set_failed,
//          |           |                          | last_of_run
//
//  A transaction is the accept, one ring rotation of CHANNEL_COUNT steps
//  through the head cell, and a finish state that may wait on the output.
//  Reset clears all channels to inactive; no clearing pass is needed.
//  A tick with several fires holds the ring while the result register is full
//  and stalled, so output stalls lengthen that transaction.
// ---------------------------------------------------------------------------
module periodic_tick_event_table #(
  parameter int unsigned CHANNEL_COUNT = ptet_pkg::CHANNEL_COUNT_DEF,
  parameter int unsigned COUNT_BITS    = ptet_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        req_type_i,
  input  logic [ptet_pkg::PERIOD_BITS-1:0]  period_ticks_i,
  input  logic [ptet_pkg::CHAN_ID_BITS-1:0] target_channel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              result_kind_o,
  output logic [ptet_pkg::CHAN_ID_BITS-1:0] channel_id_o,
  output logic                              set_failed_o,
  output logic                              last_of_run_o
);
  import ptet_pkg::*;

  localparam int unsigned TAG_BITS = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  logic                  act_w   [CHANNEL_COUNT];
  logic [TAG_BITS-1:0]   tag_w   [CHANNEL_COUNT];
  logic [COUNT_BITS-1:0] rel_w   [CHANNEL_COUNT];
  logic [COUNT_BITS-1:0] cnt_w   [CHANNEL_COUNT];

  logic                  shift;
  logic                  new_active;
  logic [TAG_BITS-1:0]   new_tag;
  logic [COUNT_BITS-1:0] new_reload;
  logic [COUNT_BITS-1:0] new_count;
  res_t                  res;

  for (genvar i = 0; i < CHANNEL_COUNT; i++) begin : g_ring
    if (i == CHANNEL_COUNT - 1) begin : g_tail
      ptet_cell #(
        .TAG_BITS  (TAG_BITS),
        .COUNT_BITS(COUNT_BITS),
        .INDEX     (i)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .active_i(new_active),
        .tag_i   (new_tag),
        .reload_i(new_reload),
        .count_i (new_count),
        .active_o(act_w[i]),
        .tag_o   (tag_w[i]),
        .reload_o(rel_w[i]),
        .count_o (cnt_w[i])
      );
    end else begin : g_body
      ptet_cell #(
        .TAG_BITS  (TAG_BITS),
        .COUNT_BITS(COUNT_BITS),
        .INDEX     (i)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .active_i(act_w[i+1]),
        .tag_i   (tag_w[i+1]),
        .reload_i(rel_w[i+1]),
        .count_i (cnt_w[i+1]),
        .active_o(act_w[i]),
        .tag_o   (tag_w[i]),
        .reload_o(rel_w[i]),
        .count_o (cnt_w[i])
      );
    end
  end

  ptet_ctrl #(
    .CHANNEL_COUNT(CHANNEL_COUNT),
    .COUNT_BITS   (COUNT_BITS),
    .TAG_BITS     (TAG_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .period_ticks_i  (period_ticks_i),
    .target_channel_i(target_channel_i),
    .head_active_i   (act_w[0]),
    .head_tag_i      (tag_w[0]),
    .head_reload_i   (rel_w[0]),
    .head_count_i    (cnt_w[0]),
    .shift_o         (shift),
    .new_active_o    (new_active),
    .new_tag_o       (new_tag),
    .new_reload_o    (new_reload),
    .new_count_o     (new_count),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .res_o           (res)
  );

  assign result_kind_o = res.kind;
  assign channel_id_o  = res.chan;
  assign set_failed_o  = res.failed;
  assign last_of_run_o = res.last;

endmodule
